// ----- rtl/hcbd_pkg.sv -----
// hcbd_pkg: types and constants of the chunked body decoder
// no dependencies; used by the channel interfaces and the core
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int LEN_BITS = 32;
  localparam int BODY_LEN_W = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_END_CR  = 3'd5,
    PH_END_LF  = 3'd6,
    PH_ERROR   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef logic [LEN_BITS-1:0] len_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/hcbd_if.sv -----
// hcbd_byte_if and hcbd_result_if: valid/ready channels of the decoder
// depends on hcbd_pkg
`timescale 1ns / 1ps

interface hcbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface hcbd_result_if;
  logic                                valid;
  logic                                ready;
  hcbd_pkg::kind_t                     kind;
  logic [7:0]                          data_byte;
  logic [hcbd_pkg::BODY_LEN_W-1:0]     body_length;

  modport source (output valid, output kind, output data_byte, output body_length,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input body_length,
                output ready);
endinterface

// ----- rtl/http_chunked_body_decoder_core.sv -----
// http_chunked_body_decoder_core: chunk framing parser, one byte per cycle unless the result stalls
// the result of a taken byte is held in the output register from the next cycle
// throughput: one byte per cycle while result.ready is high; the output register frees as it is taken
// the state update is a single pass of parse logic with the length adds and compares
// reset: rst clears parser state, running total and output valid
// depends on hcbd_pkg and hcbd_if
`timescale 1ns / 1ps

module http_chunked_body_decoder_core (
  input logic          clk,
  input logic          rst,
  hcbd_byte_if.sink    stream,
  hcbd_result_if.source result
);
  import hcbd_pkg::*;

  phase_t      phase, phase_next;
  len_t        chunk_count, chunk_count_next;
  logic        digit_seen, digit_seen_next;
  len_t        total_length, total_length_next;

  kind_t       kind_next;
  logic [7:0]  data_next;
  len_t        len_out;

  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_data;
  logic [BODY_LEN_W-1:0] out_length;

  logic        take;
  hex_digit_t  hex;
  logic [LEN_BITS:0] len_sum;
  logic [63:0] len_wide;

  assign stream.ready = !out_valid || result.ready;
  assign take         = stream.valid && stream.ready;
  assign hex          = hex_decode(stream.byte_in);
  assign len_sum      = {1'b0, chunk_count} + {1'b0, total_length};

  // next state
  always_comb begin
    phase_next        = phase;
    chunk_count_next  = chunk_count;
    digit_seen_next   = digit_seen;
    total_length_next = total_length;
    unique case (phase)
      PH_SIZE: begin
        if (hex.is_hex) begin
          if (|chunk_count[LEN_BITS-1 -: 4]) begin
            phase_next = PH_ERROR;
          end else begin
            chunk_count_next = {chunk_count[LEN_BITS-5:0], hex.value};
            digit_seen_next  = 1'b1;
          end
        end else if (stream.byte_in == CHAR_CR && digit_seen) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_SIZE_LF: begin
        priority if (stream.byte_in != CHAR_LF) begin
          phase_next = PH_ERROR;
        end else if (len_sum[LEN_BITS]) begin
          phase_next = PH_ERROR;
        end else if (chunk_count == '0) begin
          phase_next = PH_END_CR;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        total_length_next = total_length + 1'b1;
        chunk_count_next  = chunk_count - 1'b1;
        if (chunk_count == len_t'(1)) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        phase_next = (stream.byte_in == CHAR_CR) ? PH_DATA_LF : PH_ERROR;
      end
      PH_DATA_LF: begin
        if (stream.byte_in == CHAR_LF) begin
          phase_next       = PH_SIZE;
          chunk_count_next = '0;
          digit_seen_next  = 1'b0;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_END_CR: begin
        phase_next = (stream.byte_in == CHAR_CR) ? PH_END_LF : PH_ERROR;
      end
      PH_END_LF: begin
        if (stream.byte_in == CHAR_LF) begin
          phase_next        = PH_SIZE;
          chunk_count_next  = '0;
          digit_seen_next   = 1'b0;
          total_length_next = '0;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_ERROR: begin
        phase_next = PH_ERROR;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  // result of this request
  always_comb begin
    kind_next = KIND_FRAME;
    data_next = 8'h00;
    len_out   = total_length;
    if (phase_next == PH_ERROR) begin
      kind_next = KIND_ERROR;
    end else if (phase == PH_DATA) begin
      kind_next = KIND_DATA;
      data_next = stream.byte_in;
      len_out   = total_length_next;
    end else if (phase == PH_END_LF) begin
      kind_next = KIND_DONE;
    end
  end

  assign len_wide = 64'(len_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIZE;
      chunk_count  <= '0;
      digit_seen   <= 1'b0;
      total_length <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        chunk_count  <= chunk_count_next;
        digit_seen   <= digit_seen_next;
        total_length <= total_length_next;
        out_valid    <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_kind   <= kind_next;
      out_data   <= data_next;
      out_length <= len_wide[BODY_LEN_W-1:0];
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.data_byte   = out_data;
  assign result.body_length = out_length;

`ifndef NO_ASSERTIONS
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |=> phase == PH_ERROR)
    else $error("error phase left without reset");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ERROR |-> phase == PH_ERROR)
    else $error("error result without error phase");

  a_data_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data != 8'h00 |-> out_kind == KIND_DATA)
    else $error("data byte on a non-data result");

  a_data_path: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_DATA |=> out_valid && out_kind == KIND_DATA)
    else $error("data request did not give a data result");

  a_total_kept: assert property (@(posedge clk) disable iff (rst)
    take && (phase == PH_SIZE || phase == PH_SIZE_LF || phase == PH_DATA_CR)
    |=> $stable(total_length))
    else $error("total changed on a framing byte");
`endif

endmodule
